/* sv/tbq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbq_pkg: shared types and helpers for the trackball drag quaternion block
// Coordinate format, pipeline step counts, stage records and the single
// digit steps of the square root and divider chains.
// ----------------------------------------------------------------------------
package tbq_pkg;

    // Significant bits of each input coordinate (8..16)
    localparam int COORD_WIDTH = 16;

    localparam int SQRT_STEPS     = 31;  // 62-bit radicand, 31 root bits
    localparam int LIFT_DIV_STEPS = 15;  // hyperbola height quotient bits
    localparam int T2_DIV_STEPS   = 30;  // squared sine quotient bits
    localparam int Q_DIV_STEPS    = 15;  // axis component quotient bits

    // Eight single stages plus the digit chains with their init stages
    localparam int PIPE_DEPTH = 8 + 2 * (SQRT_STEPS + 1) + (LIFT_DIV_STEPS + 1)
                              + (T2_DIV_STEPS + 1) + (Q_DIV_STEPS + 1);

    localparam logic [14:0] RADIUS_RST    = 15'd26214;
    localparam logic [29:0] RADIUS_RST_SQ = 30'(26214 * 26214);
    localparam logic [30:0] T_ONE         = 31'h4000_0000;
    localparam logic [14:0] W_ONE         = 15'd16384;

    typedef struct packed {
        logic               same;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } drag_t;

    typedef struct packed {
        logic [61:0] rad;
        logic [32:0] rem;
        logic [30:0] root;
    } sqrt_t;

    typedef struct packed {
        drag_t drag;
        logic  sph_s;
        logic  sph_e;
        sqrt_t qs;
        sqrt_t qe;
    } lift_t;

    typedef struct packed {
        logic        sph;
        logic        den_zero;
        logic [14:0] zsph;
        logic [30:0] den;
        logic [31:0] rem;
        logic [14:0] num_lo;
        logic [14:0] quo;
    } ldiv_t;

    typedef struct packed {
        drag_t drag;
        ldiv_t ds;
        ldiv_t de;
    } lz_t;

    typedef struct packed {
        logic [29:0] rem;
        logic [29:0] num_lo;
        logic [29:0] quo;
    } tdiv_t;

    typedef struct packed {
        logic        same;
        logic        sat;
        logic [2:0]  neg;
        logic [29:0] m0;
        logic [29:0] m1;
        logic [29:0] m2;
        tdiv_t       dv;
    } tnrm_t;

    typedef struct packed {
        logic        same;
        logic [2:0]  neg;
        logic [29:0] m0;
        logic [29:0] m1;
        logic [29:0] m2;
        sqrt_t       st;
        sqrt_t       sw;
        sqrt_t       sn;
    } sq2_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [14:0] num_lo;
        logic [14:0] quo;
    } qdiv_t;

    typedef struct packed {
        logic        same;
        logic        naz;
        logic [2:0]  neg;
        logic [30:0] na;
        logic [14:0] wq;
        qdiv_t       d0;
        qdiv_t       d1;
        qdiv_t       d2;
    } qd_t;

    // Raw coordinate to Q1.15 (exact scale-up for narrow coordinates)
    function automatic logic signed [15:0] to_q15(input logic [15:0] raw);
        logic signed [COORD_WIDTH-1:0] c;
        c = raw[COORD_WIDTH-1:0];
        return 16'(c) <<< (16 - COORD_WIDTH);
    endfunction

    // One root bit of the floor square root
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t       r;
        logic [34:0] rem2;
        logic [34:0] trial;
        logic        ge;
        rem2   = {s.rem, s.rad[61:60]};
        trial  = {2'b00, s.root, 2'b01};
        ge     = rem2 >= trial;
        r.rem  = ge ? 33'(rem2 - trial) : 33'(rem2);
        r.root = {s.root[29:0], ge};
        r.rad  = {s.rad[59:0], 2'b00};
        return r;
    endfunction

    // One quotient bit of the hyperbola height division
    function automatic ldiv_t ldiv_step(input ldiv_t s);
        ldiv_t       r;
        logic [31:0] rem2;
        logic        ge;
        rem2     = {s.rem[30:0], s.num_lo[14]};
        ge       = rem2 >= {1'b0, s.den};
        r        = s;
        r.rem    = ge ? rem2 - {1'b0, s.den} : rem2;
        r.num_lo = {s.num_lo[13:0], 1'b0};
        r.quo    = {s.quo[13:0], ge};
        return r;
    endfunction

    // One quotient bit of the squared sine division
    function automatic tdiv_t tdiv_step(input tdiv_t s, input logic [29:0] den);
        tdiv_t       r;
        logic [30:0] rem2;
        logic        ge;
        rem2     = {s.rem, s.num_lo[29]};
        ge       = rem2 >= {1'b0, den};
        r.rem    = ge ? 30'(rem2 - {1'b0, den}) : rem2[29:0];
        r.num_lo = {s.num_lo[28:0], 1'b0};
        r.quo    = {s.quo[28:0], ge};
        return r;
    endfunction

    // One quotient bit of the axis component division
    function automatic qdiv_t qdiv_step(input qdiv_t s, input logic [30:0] den);
        qdiv_t       r;
        logic [31:0] rem2;
        logic        ge;
        rem2     = {s.rem, s.num_lo[14]};
        ge       = rem2 >= {1'b0, den};
        r.rem    = ge ? 31'(rem2 - {1'b0, den}) : rem2[30:0];
        r.num_lo = {s.num_lo[13:0], 1'b0};
        r.quo    = {s.quo[13:0], ge};
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/trackball_drag_to_quaternion.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// trackball_drag_to_quaternion: pointer drag to rotation quaternion
// Lifts both drag points onto the virtual ball, forms the cross-product axis
// and the sine term, and emits the unit rotation quaternion in Q2.14.
// ----------------------------------------------------------------------------
// Accepts one beat per cycle while the output is not held; the depth
// (PIPE_DEPTH) comes from the digit chains (square roots and dividers),
// each resolving one result bit per stage.
// The whole pipe holds while a finished beat waits on out_stall.
// Reset clears all valid bits and sets the radius to 0.8 (26214).
module trackball_drag_to_quaternion (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [14:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic [14:0]             quat_w
);
    import tbq_pkg::*;

    // ---------------- control ----------------
    logic                  adv;
    logic                  in_acc;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [14:0]           radius_reg;
    logic [29:0]           r2_reg;
    logic [14:0]           r_eff;

    assign adv       = !vld_reg[PIPE_DEPTH-1] || !out_stall;
    assign in_stall  = !adv;
    assign in_acc    = in_valid && adv;
    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign vld_next  = {vld_reg[PIPE_DEPTH-2:0], in_acc};
    assign r_eff     = (radius_reg == 15'd0) ? 15'd1 : radius_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // radius register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            r2_reg     <= RADIUS_RST_SQ;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            r2_reg <= r_eff * r_eff;
        end
    end

    // ---------------- P0: input register ----------------
    drag_t drag0_reg;
    drag_t drag0_next;

    always_comb
    begin
        drag0_next.sx   = to_q15(start_x);
        drag0_next.sy   = to_q15(start_y);
        drag0_next.ex   = to_q15(end_x);
        drag0_next.ey   = to_q15(end_y);
        drag0_next.same = (drag0_next.sx == drag0_next.ex)
                       && (drag0_next.sy == drag0_next.ey);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drag0_reg <= drag0_next;
        end
    end

    // ---------------- P1: squared distances ----------------
    drag_t              drag1_reg;
    logic [31:0]        d2s_reg;
    logic [31:0]        d2e_reg;
    logic signed [31:0] sxx, syy, exx, eyy;

    assign sxx = drag0_reg.sx * drag0_reg.sx;
    assign syy = drag0_reg.sy * drag0_reg.sy;
    assign exx = drag0_reg.ex * drag0_reg.ex;
    assign eyy = drag0_reg.ey * drag0_reg.ey;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drag1_reg <= drag0_reg;
            d2s_reg   <= $unsigned(sxx) + $unsigned(syy);
            d2e_reg   <= $unsigned(exx) + $unsigned(eyy);
        end
    end

    // ---------------- lift square roots ----------------
    lift_t lift_reg [0:SQRT_STEPS];
    lift_t lift0_next;
    logic  sph_s, sph_e;

    assign sph_s = {d2s_reg, 1'b0} < 33'(r2_reg);
    assign sph_e = {d2e_reg, 1'b0} < 33'(r2_reg);

    // sphere radicand r^2-d^2, hyperbola radicand d^2 << 30
    always_comb
    begin
        lift0_next.drag    = drag1_reg;
        lift0_next.sph_s   = sph_s;
        lift0_next.sph_e   = sph_e;
        lift0_next.qs.rad  = sph_s ? 62'(r2_reg - d2s_reg[29:0]) : {d2s_reg, 30'd0};
        lift0_next.qs.rem  = '0;
        lift0_next.qs.root = '0;
        lift0_next.qe.rad  = sph_e ? 62'(r2_reg - d2e_reg[29:0]) : {d2e_reg, 30'd0};
        lift0_next.qe.rem  = '0;
        lift0_next.qe.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lift_reg[0] <= lift0_next;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_lift_sqrt
        lift_t lift_next;

        always_comb
        begin
            lift_next    = lift_reg[k-1];
            lift_next.qs = sqrt_step(lift_reg[k-1].qs);
            lift_next.qe = sqrt_step(lift_reg[k-1].qe);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lift_reg[k] <= lift_next;
            end
        end
    end

    // ---------------- hyperbola height division ----------------
    lz_t   lz_reg [0:LIFT_DIV_STEPS];
    lz_t   lz0_next;
    lift_t lift_last;

    assign lift_last = lift_reg[SQRT_STEPS];

    // quotient (r^2 << 14) / ds, below 2^15 on the hyperbola
    always_comb
    begin
        lz0_next.drag        = lift_last.drag;
        lz0_next.ds.sph      = lift_last.sph_s;
        lz0_next.ds.den_zero = lift_last.qs.root == 31'd0;
        lz0_next.ds.zsph     = lift_last.qs.root[14:0];
        lz0_next.ds.den      = lift_last.qs.root;
        lz0_next.ds.rem      = 32'(r2_reg[29:1]);
        lz0_next.ds.num_lo   = {r2_reg[0], 14'd0};
        lz0_next.ds.quo      = '0;
        lz0_next.de.sph      = lift_last.sph_e;
        lz0_next.de.den_zero = lift_last.qe.root == 31'd0;
        lz0_next.de.zsph     = lift_last.qe.root[14:0];
        lz0_next.de.den      = lift_last.qe.root;
        lz0_next.de.rem      = 32'(r2_reg[29:1]);
        lz0_next.de.num_lo   = {r2_reg[0], 14'd0};
        lz0_next.de.quo      = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lz_reg[0] <= lz0_next;
        end
    end

    for (genvar k = 1; k <= LIFT_DIV_STEPS; k++)
    begin : g_lift_div
        lz_t lz_next;

        always_comb
        begin
            lz_next    = lz_reg[k-1];
            lz_next.ds = ldiv_step(lz_reg[k-1].ds);
            lz_next.de = ldiv_step(lz_reg[k-1].de);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lz_reg[k] <= lz_next;
            end
        end
    end

    // ---------------- P3: lifted heights ----------------
    drag_t       drag3_reg;
    logic [14:0] zs_reg, ze_reg;
    lz_t         lz_last;

    assign lz_last = lz_reg[LIFT_DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drag3_reg <= lz_last.drag;
            zs_reg    <= lz_last.ds.sph ? lz_last.ds.zsph
                       : (lz_last.ds.den_zero ? 15'd0 : lz_last.ds.quo);
            ze_reg    <= lz_last.de.sph ? lz_last.de.zsph
                       : (lz_last.de.den_zero ? 15'd0 : lz_last.de.quo);
        end
    end

    // ---------------- P4: cross and difference products ----------------
    logic               same4_reg;
    logic signed [31:0] crs_reg [0:5];
    logic signed [33:0] dx2_reg, dy2_reg;
    logic signed [31:0] dz2_reg;
    logic signed [15:0] szs, ezs, dz;
    logic signed [16:0] dx, dy;

    assign szs = $signed({1'b0, zs_reg});
    assign ezs = $signed({1'b0, ze_reg});
    assign dx  = 17'(drag3_reg.sx) - 17'(drag3_reg.ex);
    assign dy  = 17'(drag3_reg.sy) - 17'(drag3_reg.ey);
    assign dz  = szs - ezs;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            same4_reg  <= drag3_reg.same;
            crs_reg[0] <= drag3_reg.ey * szs;
            crs_reg[1] <= ezs * drag3_reg.sy;
            crs_reg[2] <= ezs * drag3_reg.sx;
            crs_reg[3] <= drag3_reg.ex * szs;
            crs_reg[4] <= drag3_reg.ex * drag3_reg.sy;
            crs_reg[5] <= drag3_reg.ey * drag3_reg.sx;
            dx2_reg    <= dx * dx;
            dy2_reg    <= dy * dy;
            dz2_reg    <= dz * dz;
        end
    end

    // ---------------- P5: axis and chord length ----------------
    logic               same5_reg;
    logic signed [32:0] a_reg [0:2];
    logic [34:0]        dd2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            same5_reg <= same4_reg;
            a_reg[0]  <= 33'(crs_reg[0]) - 33'(crs_reg[1]);
            a_reg[1]  <= 33'(crs_reg[2]) - 33'(crs_reg[3]);
            a_reg[2]  <= 33'(crs_reg[4]) - 33'(crs_reg[5]);
            dd2_reg   <= 35'($unsigned(dx2_reg)) + 35'($unsigned(dy2_reg))
                       + 35'($unsigned(dz2_reg));
        end
    end

    // ---------------- P6 + sine division ----------------
    tnrm_t       tq_reg [0:T2_DIV_STEPS];
    tnrm_t       tq0_next;
    logic [31:0] mag [0:2];
    logic [31:0] mx;
    logic [1:0]  nsh;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = 32'(a_reg[i][32] ? -a_reg[i] : a_reg[i]);
        end
        mx  = (mag[0] > mag[1]) ? mag[0] : mag[1];
        mx  = (mx > mag[2]) ? mx : mag[2];
        nsh = mx[31] ? 2'd2 : (mx[30] ? 2'd1 : 2'd0);
    end

    // t^2 = (dd2 << 28) / r^2, saturating once dd2 >= 4 r^2
    always_comb
    begin
        tq0_next.same      = same5_reg;
        tq0_next.sat       = dd2_reg >= 35'({r2_reg, 2'b00});
        tq0_next.neg       = {a_reg[2][32], a_reg[1][32], a_reg[0][32]};
        tq0_next.m0        = 30'(mag[0] >> nsh);
        tq0_next.m1        = 30'(mag[1] >> nsh);
        tq0_next.m2        = 30'(mag[2] >> nsh);
        tq0_next.dv.rem    = 30'(dd2_reg >> 2);
        tq0_next.dv.num_lo = {dd2_reg[1:0], 28'd0};
        tq0_next.dv.quo    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tq_reg[0] <= tq0_next;
        end
    end

    for (genvar k = 1; k <= T2_DIV_STEPS; k++)
    begin : g_t2_div
        tnrm_t tq_next;

        always_comb
        begin
            tq_next    = tq_reg[k-1];
            tq_next.dv = tdiv_step(tq_reg[k-1].dv, r2_reg);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tq_reg[k] <= tq_next;
            end
        end
    end

    // ---------------- P7: saturated t^2, axis squares ----------------
    logic        same7_reg;
    logic [2:0]  neg7_reg;
    logic [29:0] m7_reg [0:2];
    logic [59:0] mm7_reg [0:2];
    logic [30:0] t2_7_reg;
    tnrm_t       tq_last;

    assign tq_last = tq_reg[T2_DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            same7_reg  <= tq_last.same;
            neg7_reg   <= tq_last.neg;
            m7_reg[0]  <= tq_last.m0;
            m7_reg[1]  <= tq_last.m1;
            m7_reg[2]  <= tq_last.m2;
            mm7_reg[0] <= tq_last.m0 * tq_last.m0;
            mm7_reg[1] <= tq_last.m1 * tq_last.m1;
            mm7_reg[2] <= tq_last.m2 * tq_last.m2;
            t2_7_reg   <= tq_last.sat ? T_ONE : {1'b0, tq_last.dv.quo};
        end
    end

    // ---------------- P8 + t, w and norm square roots ----------------
    sq2_t sq2_reg [0:SQRT_STEPS];
    sq2_t sq20_next;

    always_comb
    begin
        sq20_next.same    = same7_reg;
        sq20_next.neg     = neg7_reg;
        sq20_next.m0      = m7_reg[0];
        sq20_next.m1      = m7_reg[1];
        sq20_next.m2      = m7_reg[2];
        sq20_next.st.rad  = 62'({t2_7_reg, 30'd0});
        sq20_next.st.rem  = '0;
        sq20_next.st.root = '0;
        sq20_next.sw.rad  = 62'({31'(T_ONE - t2_7_reg), 30'd0});
        sq20_next.sw.rem  = '0;
        sq20_next.sw.root = '0;
        sq20_next.sn.rad  = 62'(mm7_reg[0]) + 62'(mm7_reg[1]) + 62'(mm7_reg[2]);
        sq20_next.sn.rem  = '0;
        sq20_next.sn.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq2_reg[0] <= sq20_next;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_out_sqrt
        sq2_t sq2_next;

        always_comb
        begin
            sq2_next    = sq2_reg[k-1];
            sq2_next.st = sqrt_step(sq2_reg[k-1].st);
            sq2_next.sw = sqrt_step(sq2_reg[k-1].sw);
            sq2_next.sn = sqrt_step(sq2_reg[k-1].sn);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq2_reg[k] <= sq2_next;
            end
        end
    end

    // ---------------- P9: scaled axis, rounded w ----------------
    logic        same9_reg;
    logic        naz9_reg;
    logic [2:0]  neg9_reg;
    logic [30:0] na9_reg;
    logic [14:0] wq9_reg;
    logic [60:0] pm9_reg [0:2];
    sq2_t        sq2_last;
    logic [31:0] w_rnd;

    assign sq2_last = sq2_reg[SQRT_STEPS];
    assign w_rnd    = 32'(sq2_last.sw.root) + 32'h0000_8000;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            same9_reg  <= sq2_last.same;
            naz9_reg   <= sq2_last.sn.root == 31'd0;
            neg9_reg   <= sq2_last.neg;
            na9_reg    <= sq2_last.sn.root;
            wq9_reg    <= w_rnd[30:16];
            pm9_reg[0] <= sq2_last.m0 * sq2_last.st.root;
            pm9_reg[1] <= sq2_last.m1 * sq2_last.st.root;
            pm9_reg[2] <= sq2_last.m2 * sq2_last.st.root;
        end
    end

    // ---------------- P10 + component division ----------------
    qd_t         qd_reg [0:Q_DIV_STEPS];
    qd_t         qd0_next;
    logic [61:0] qsum [0:2];

    // round(m*t / (na << 16)) = floor(((m*t + na*2^15) >> 16) / na)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qsum[i] = 62'(pm9_reg[i]) + 62'({na9_reg, 15'd0});
        end
        qd0_next.same      = same9_reg;
        qd0_next.naz       = naz9_reg;
        qd0_next.neg       = neg9_reg;
        qd0_next.na        = na9_reg;
        qd0_next.wq        = wq9_reg;
        qd0_next.d0.rem    = qsum[0][61:31];
        qd0_next.d0.num_lo = qsum[0][30:16];
        qd0_next.d0.quo    = '0;
        qd0_next.d1.rem    = qsum[1][61:31];
        qd0_next.d1.num_lo = qsum[1][30:16];
        qd0_next.d1.quo    = '0;
        qd0_next.d2.rem    = qsum[2][61:31];
        qd0_next.d2.num_lo = qsum[2][30:16];
        qd0_next.d2.quo    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qd_reg[0] <= qd0_next;
        end
    end

    for (genvar k = 1; k <= Q_DIV_STEPS; k++)
    begin : g_q_div
        qd_t qd_next;

        always_comb
        begin
            qd_next    = qd_reg[k-1];
            qd_next.d0 = qdiv_step(qd_reg[k-1].d0, qd_reg[k-1].na);
            qd_next.d1 = qdiv_step(qd_reg[k-1].d1, qd_reg[k-1].na);
            qd_next.d2 = qdiv_step(qd_reg[k-1].d2, qd_reg[k-1].na);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qd_reg[k] <= qd_next;
            end
        end
    end

    // ---------------- P11: output register ----------------
    logic signed [15:0] qx_reg, qy_reg, qz_reg;
    logic [14:0]        qw_reg;
    qd_t                qd_last;
    logic               ident;
    logic [15:0]        qv0, qv1, qv2;

    assign qd_last = qd_reg[Q_DIV_STEPS];
    assign ident   = qd_last.same || qd_last.naz;
    assign qv0     = {1'b0, qd_last.d0.quo};
    assign qv1     = {1'b0, qd_last.d1.quo};
    assign qv2     = {1'b0, qd_last.d2.quo};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= ident ? 16'sd0 : $signed(qd_last.neg[0] ? -qv0 : qv0);
            qy_reg <= ident ? 16'sd0 : $signed(qd_last.neg[1] ? -qv1 : qv1);
            qz_reg <= ident ? 16'sd0 : $signed(qd_last.neg[2] ? -qv2 : qv2);
            qw_reg <= ident ? W_ONE : qd_last.wq;
        end
    end

    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;
    assign quat_w = qw_reg;

`ifndef SYNTHESIS
    // a held output beat freezes the whole pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output beat is held");

    // an accepted beat occupies the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted beat lost at pipe entry");

    // the w and x components stay within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= W_ONE && quat_x >= -16'sd16384
                       && quat_x <= 16'sd16384))
        else $error("quaternion component out of range");
`endif

endmodule
`default_nettype wire

/* tb/trackball_drag_to_quaternion_checker.sv */
// ----------------------------------------------------------------------------
// trackball_drag_to_quaternion_checker: rotation predictor and output check
// Watches the drag and quaternion channels and the radius write port. Every
// accepted drag beat is turned into an expected quaternion. Every accepted
// output beat is compared with the oldest expected quaternion, field by field.
// ----------------------------------------------------------------------------
module trackball_drag_to_quaternion_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [14:0]        cfg_wdata,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic [14:0]        quat_w,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [15:0] qx;
        logic [15:0] qy;
        logic [15:0] qz;
        logic [14:0] qw;
    } quat_t;

    quat_t       quat_queue[$];
    logic [14:0] ball_radius;

    // Floor square root, one root bit per pass
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Height of a point lifted onto the sphere or the hyperbolic sheet
    function automatic longint lifted_z(input longint x, input longint y,
                                        input longint unsigned r);
        longint unsigned d2;
        longint unsigned r2;
        longint unsigned ds;
        d2 = longint'(x * x) + longint'(y * y);
        r2 = r * r;
        if (2 * d2 < r2)
            return longint'(floor_sqrt(r2 - d2));
        ds = floor_sqrt(d2 << 30);
        if (ds == 0)
            return 0;
        return longint'((r2 << 14) / ds);
    endfunction

    function automatic quat_t drag_rotation(input logic signed [15:0] sx,
                                            input logic signed [15:0] sy,
                                            input logic signed [15:0] ex,
                                            input logic signed [15:0] ey,
                                            input logic [14:0] radius);
        quat_t           q;
        longint          p1[3];
        longint          p2[3];
        longint          ax[3];
        longint          dv;
        longint unsigned mag[3];
        longint unsigned r, mx, n2, na, dd2, t2, t30, w30, den, qv;
        q.qx = 16'd0;
        q.qy = 16'd0;
        q.qz = 16'd0;
        q.qw = 15'd16384;
        r = (radius == 0) ? 1 : radius;
        if (sx == ex && sy == ey)
            return q;
        // COORD_WIDTH is 16, so coordinates are already Q1.15
        p1[0] = sx;
        p1[1] = sy;
        p2[0] = ex;
        p2[1] = ey;
        p1[2] = lifted_z(p1[0], p1[1], r);
        p2[2] = lifted_z(p2[0], p2[1], r);
        ax[0] = p2[1] * p1[2] - p2[2] * p1[1];
        ax[1] = p2[2] * p1[0] - p2[0] * p1[2];
        ax[2] = p2[0] * p1[1] - p2[1] * p1[0];
        // squared sine term, saturated to one
        dd2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            dv  = p1[i] - p2[i];
            dd2 = dd2 + longint'(dv * dv);
        end
        t2 = (dd2 << 28) / (r * r);
        if (t2 > (64'd1 << 30))
            t2 = 64'd1 << 30;
        t30 = floor_sqrt(t2 << 30);
        w30 = floor_sqrt(((64'd1 << 30) - t2) << 30);
        // axis magnitudes brought below 2^30
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (ax[i] < 0) ? longint'(-ax[i]) : longint'(ax[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        n2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        na = floor_sqrt(n2);
        if (na == 0)
            return q;
        den = na << 16;
        for (int i = 0; i < 3; i++)
        begin
            qv = (2 * mag[i] * t30 + den) / (2 * den);
            if (ax[i] < 0)
                qv = 0 - qv;
            if (i == 0) q.qx = qv[15:0];
            else if (i == 1) q.qy = qv[15:0];
            else q.qz = qv[15:0];
        end
        qv   = (w30 + (64'd1 << 15)) >> 16;
        q.qw = qv[14:0];
        return q;
    endfunction

    assign pending = quat_queue.size();

    // Track radius, predict on drag beats, compare on quaternion beats
    always @(posedge clk or negedge rst_n)
    begin
        quat_t want;
        if (!rst_n)
        begin
            ball_radius = 15'd26214;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
                ball_radius = cfg_wdata;
            if (in_valid && !in_stall)
                quat_queue.push_back(drag_rotation(start_x, start_y, end_x, end_y,
                                                   ball_radius));
            if (out_valid && !out_stall)
            begin
                if (quat_queue.size() == 0)
                begin
                    $error("unexpected quaternion beat x=%0d y=%0d z=%0d w=%0d",
                           quat_x, quat_y, quat_z, quat_w);
                    fail_count++;
                end
                else
                begin
                    want = quat_queue.pop_front();
                    if (quat_x !== want.qx)
                    begin
                        $error("quat_x expected %0d actual %0d",
                               $signed(want.qx), quat_x);
                        fail_count++;
                    end
                    if (quat_y !== want.qy)
                    begin
                        $error("quat_y expected %0d actual %0d",
                               $signed(want.qy), quat_y);
                        fail_count++;
                    end
                    if (quat_z !== want.qz)
                    begin
                        $error("quat_z expected %0d actual %0d",
                               $signed(want.qz), quat_z);
                        fail_count++;
                    end
                    if (quat_w !== want.qw)
                    begin
                        $error("quat_w expected %0d actual %0d", want.qw, quat_w);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/trackball_drag_to_quaternion_tb.sv */
// ----------------------------------------------------------------------------
// trackball_drag_to_quaternion_tb: stimulus and verdict for the trackball
// Drives directed and random drags under several ball radii with random
// idling on both channels, a long output hold-off, and a checker alongside.
// ----------------------------------------------------------------------------
module trackball_drag_to_quaternion_tb;

    localparam int LATENCY   = 135;
    localparam int N_RANDOM  = 190;
    localparam int HOLD_LEN  = 400;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [14:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [14:0]        quat_w;
    int                 fail_count;
    int                 pending;
    logic               calm;      // no idling on either side
    logic               hold_go;   // ask the receiver for one long hold-off

    trackball_drag_to_quaternion u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w)
    );

    trackball_drag_to_quaternion_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #30000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall, one long hold-off on request
    initial
    begin
        int  hold_cnt;
        bit  hold_done;
        hold_cnt  = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt >= HOLD_LEN)
                    hold_done = 1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 21);
        end
    end

    // One drag beat, with a random gap ahead of it
    task automatic send_drag(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] ex, input logic [15:0] ey);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain the pipe, then let the latency pass before a radius write
    task automatic drain_and_write(input logic [14:0] radius);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= radius;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($signed($urandom_range(2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_drags(input int count);
        logic [15:0] sx, sy, ex, ey;
        for (int i = 0; i < count; i++)
        begin
            sx = rand_coord();
            sy = rand_coord();
            if ($urandom_range(9) == 0)
            begin
                ex = sx;
                ey = sy;
            end
            else if ($urandom_range(3) == 0)
            begin
                // short drag near the start point
                ex = sx + 16'($signed($urandom_range(63)) - 32);
                ey = sy + 16'($signed($urandom_range(63)) - 32);
            end
            else
            begin
                ex = rand_coord();
                ey = rand_coord();
            end
            send_drag(sx, sy, ex, ey);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int guard;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 15'd0;
        in_valid  = 1'b0;
        start_x   = 16'sd0;
        start_y   = 16'sd0;
        end_x     = 16'sd0;
        end_y     = 16'sd0;
        calm      = 1'b0;
        hold_go   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed drags at the reset radius
        send_drag(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_drag(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_drag(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_drag(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_drag(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_drag(16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
        send_drag(16'h0000, 16'h7FFF, 16'h0000, 16'h8000);
        send_drag(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_drag(16'h1000, 16'h1000, 16'h2000, 16'h2000);
        send_drag(16'h4000, 16'h0000, 16'h7000, 16'h0000);
        send_drag(16'h2000, 16'hE000, 16'hD000, 16'h3000);
        send_drag(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
        send_drag(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        random_drags(N_RANDOM);

        // Largest radius, with the long output hold-off
        drain_and_write(15'd32767);
        hold_go = 1'b1;
        send_drag(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_drag(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        random_drags(N_RANDOM);

        // Smallest radius: sine term saturates on large drags, no idling
        drain_and_write(15'd1);
        calm = 1'b1;
        send_drag(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_drag(16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF);
        random_drags(N_RANDOM);
        calm = 1'b0;

        // Mid radius
        drain_and_write(15'd16384);
        random_drags(N_RANDOM);

        // Drain and verdict
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
